### sv/lspb_pkg.sv
// Shared types and constants for the LSPB trajectory sample unit.
// Used by lspb_front, lspb_div and lspb_trajectory_sample_unit; no dependencies.
package lspb_pkg;

  localparam int INDEX_WIDTH_DEF = 16;
  localparam int DATA_W          = 32;
  localparam int QUO_W           = 36;

  localparam logic [1:0] REG_START = 2'd0;
  localparam logic [1:0] REG_END   = 2'd1;
  localparam logic [1:0] REG_COUNT = 2'd2;

  localparam logic [1:0] SEG_ACCEL  = 2'd0;
  localparam logic [1:0] SEG_CRUISE = 2'd1;
  localparam logic [1:0] SEG_DECEL  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_SHORT = 2'd2;

  typedef struct packed {
    logic [1:0]        seg;
    logic [1:0]        status;
    logic [DATA_W-1:0] base;
    logic              pos_neg;
    logic              vel_neg;
    logic              acc_neg;
  } meta_t;

endpackage

### sv/lspb_front.sv
// Front pipeline of the LSPB unit: segment decode, squares and scaled numerators.
// Depends on lspb_pkg.
module lspb_front import lspb_pkg::*; #(
  parameter int IW = INDEX_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   acc_vld,
  input  logic [IW-1:0]          idx,
  input  logic [DATA_W-1:0]      start_pos,
  input  logic [DATA_W-1:0]      end_pos,
  input  logic [15:0]            count,
  output logic                   vld,
  output logic [2:0][2*IW+35:0]  num,
  output logic [2:0][2*IW+1:0]   den,
  output meta_t                  meta
);

  localparam int NW = 2*IW + 36;
  localparam int DW = 2*IW + 2;

  logic [IW-1:0]        n;
  logic [DATA_W:0]      diff;
  logic [DATA_W:0]      diff_abs;

  logic                 v1_r, v2_r, v3_r, v4_r;
  logic [IW-1:0]        i1_r, tf1_r;
  logic                 nlt2_1_r, oor1_r, neg1_r;
  logic [DATA_W-1:0]    mag1_r, st1_r, en1_r;

  logic [IW+1:0]        i3x, tf_x1, tf_x2;
  logic [IW+2:0]        i6;
  logic                 le1, le2;
  logic [1:0]           seg_c, status_c;
  meta_t                meta_nxt;

  logic [IW-1:0]        x2_r, tf2_r;
  logic [IW+2:0]        lin2_r;
  logic                 cru2_r;
  logic [DATA_W-1:0]    mag2_r;
  meta_t                meta2_r;

  logic [2*IW-1:0]      kp3_r, tsq3_r;
  logic [IW-1:0]        kv3_r, tf3_r;
  logic                 cru3_r;
  logic [DATA_W-1:0]    mag3_r;
  meta_t                meta3_r;

  logic [DATA_W+2*IW-1:0] pp4_r;
  logic [DATA_W+IW-1:0]   pv4_r;
  logic [DATA_W-1:0]      mag4_r;
  logic                   cru4_r;
  logic [2:0][DW-1:0]     den4_r;
  meta_t                  meta4_r;

  assign n        = IW'(count);
  assign diff     = {end_pos[DATA_W-1], end_pos} - {start_pos[DATA_W-1], start_pos};
  assign diff_abs = diff[DATA_W] ? (~diff + 1'b1) : diff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= acc_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    i1_r     <= idx;
    tf1_r    <= n - IW'(1);
    nlt2_1_r <= (n < IW'(2));
    oor1_r   <= (idx >= n);
    neg1_r   <= diff[DATA_W];
    mag1_r   <= diff_abs[DATA_W-1:0];
    st1_r    <= start_pos;
    en1_r    <= end_pos;
  end

  assign i3x   = {2'b00, i1_r} + {1'b0, i1_r, 1'b0};
  assign tf_x1 = {2'b00, tf1_r};
  assign tf_x2 = {1'b0, tf1_r, 1'b0};
  assign i6    = {1'b0, i1_r, 2'b00} + {2'b00, i1_r, 1'b0};
  assign le1   = (i3x <= tf_x1);
  assign le2   = (i3x <= tf_x2);

  always_comb begin
    seg_c    = le1 ? SEG_ACCEL : (le2 ? SEG_CRUISE : SEG_DECEL);
    status_c = nlt2_1_r ? ST_SHORT : (oor1_r ? ST_RANGE : ST_OK);
    meta_nxt.seg     = (status_c == ST_OK) ? seg_c : SEG_ACCEL;
    meta_nxt.status  = status_c;
    if (nlt2_1_r) begin
      meta_nxt.base = st1_r;
    end else if (oor1_r) begin
      meta_nxt.base = '0;
    end else if (seg_c == SEG_DECEL) begin
      meta_nxt.base = en1_r;
    end else begin
      meta_nxt.base = st1_r;
    end
    meta_nxt.pos_neg = (seg_c == SEG_DECEL) ? !neg1_r : neg1_r;
    meta_nxt.vel_neg = neg1_r;
    meta_nxt.acc_neg = (seg_c == SEG_DECEL) ? !neg1_r : neg1_r;
  end

  always_ff @(posedge clk) begin
    x2_r    <= le1 ? i1_r : (tf1_r - i1_r);
    tf2_r   <= tf1_r;
    lin2_r  <= i6 - {3'b000, tf1_r};
    cru2_r  <= (seg_c == SEG_CRUISE);
    mag2_r  <= mag1_r;
    meta2_r <= meta_nxt;
  end

  always_ff @(posedge clk) begin
    kp3_r   <= cru2_r ? (2*IW)'(lin2_r) : (x2_r * x2_r);
    tsq3_r  <= tf2_r * tf2_r;
    kv3_r   <= cru2_r ? IW'(1) : x2_r;
    tf3_r   <= tf2_r;
    cru3_r  <= cru2_r;
    mag3_r  <= mag2_r;
    meta3_r <= meta2_r;
  end

  always_ff @(posedge clk) begin
    pp4_r     <= mag3_r * kp3_r;
    pv4_r     <= mag3_r * kv3_r;
    mag4_r    <= mag3_r;
    cru4_r    <= cru3_r;
    den4_r[0] <= cru3_r ? DW'({tf3_r, 2'b00}) : {tsq3_r, 2'b00};
    den4_r[1] <= cru3_r ? DW'({tf3_r, 1'b0}) : DW'({tsq3_r, 1'b0});
    den4_r[2] <= DW'({tsq3_r, 1'b0});
    meta4_r   <= meta3_r;
  end

  assign num[0] = cru4_r ? NW'(pp4_r) : (NW'({pp4_r, 3'b000}) + NW'(pp4_r));
  assign num[1] = cru4_r ? (NW'({pv4_r, 1'b0}) + NW'(pv4_r))
                         : (NW'({pv4_r, 3'b000}) + NW'(pv4_r));
  assign num[2] = cru4_r ? '0 : (NW'({mag4_r, 3'b000}) + NW'(mag4_r));
  assign den    = den4_r;
  assign vld    = v4_r;
  assign meta   = meta4_r;

endmodule

### sv/lspb_div.sv
// Three-lane pipelined restoring divider, one quotient bit per stage, rounding to nearest.
// Depends on lspb_pkg.
module lspb_div import lspb_pkg::*; #(
  parameter int IW = INDEX_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_vld,
  input  logic [2:0][2*IW+35:0] num,
  input  logic [2:0][2*IW+1:0]  den,
  input  meta_t                 in_meta,
  output logic                  out_vld,
  output logic [2:0][QUO_W:0]   quo,
  output meta_t                 out_meta
);

  localparam int NW = 2*IW + 36;
  localparam int DW = 2*IW + 2;
  localparam int QW = QUO_W;

  logic [2:0][DW-1:0] rem_r [0:QW];
  logic [2:0][QW-1:0] w_r   [0:QW];
  logic [2:0][DW-1:0] den_r [0:QW];
  meta_t              meta_r[0:QW];
  logic               vld_r [0:QW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 3; l++) begin
      rem_r[0][l] <= DW'(num[l][NW-1:QW]);
      w_r[0][l]   <= num[l][QW-1:0];
      den_r[0][l] <= den[l];
    end
    meta_r[0] <= in_meta;
  end

  for (genvar g = 0; g < QW; g++) begin : g_step
    logic [2:0][DW:0]   trial;
    logic [2:0]         ge;
    logic [2:0][DW:0]   diffv;

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        trial[l] = {rem_r[g][l], w_r[g][l][QW-1]};
        ge[l]    = (trial[l] >= {1'b0, den_r[g][l]});
        diffv[l] = trial[l] - {1'b0, den_r[g][l]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g+1] <= 1'b0;
      end else begin
        vld_r[g+1] <= vld_r[g];
      end
    end

    always_ff @(posedge clk) begin
      for (int l = 0; l < 3; l++) begin
        rem_r[g+1][l] <= ge[l] ? diffv[l][DW-1:0] : trial[l][DW-1:0];
        w_r[g+1][l]   <= {w_r[g][l][QW-2:0], ge[l]};
        den_r[g+1][l] <= den_r[g][l];
      end
      meta_r[g+1] <= meta_r[g];
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      quo[l] = {1'b0, w_r[QW][l]}
             + (QW+1)'({rem_r[QW][l], 1'b0} >= {1'b0, den_r[QW][l]});
    end
  end

  assign out_vld  = vld_r[QW];
  assign out_meta = meta_r[QW];

endmodule

### sv/lspb_trajectory_sample_unit.sv
// Top level of the LSPB trajectory sample unit: configuration registers and output stage.
// Depends on lspb_pkg, lspb_front and lspb_div.
//
// Usage:
//   Configuration is written through cfg_valid/cfg_ready with cfg_index selecting
//   start position, end position or sample count and cfg_data carrying the value.
//   cfg_ready is always high; writes should only be made while no transaction is
//   in flight. Writes to an unknown index are ignored.
//   A sample index is taken on every clock edge at which start is high and busy
//   is low. busy is never raised, so one transaction can be accepted every cycle.
//   Each transaction produces exactly one result, presented for one cycle with
//   out_valid high. On its way each transaction passes through the four
//   front stages, the divider input register, 36 one-bit divider stages and the
//   output register.
//   The receiver cannot stall the block; results must be captured when shown.
//   Synchronous reset clears the configuration registers to zero and empties
//   the pipeline; nothing in flight at reset is delivered.
module lspb_trajectory_sample_unit import lspb_pkg::*; #(
  parameter int INDEX_WIDTH = INDEX_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [INDEX_WIDTH-1:0] in_sample_index,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [DATA_W-1:0]      cfg_data,
  output logic                   out_valid,
  output logic [DATA_W-1:0]      out_position,
  output logic [DATA_W-1:0]      out_velocity,
  output logic [DATA_W-1:0]      out_acceleration,
  output logic [1:0]             out_segment,
  output logic [1:0]             out_status
);

  localparam int IW = INDEX_WIDTH;
  localparam int SUM_W = QUO_W + 4;

  logic [DATA_W-1:0]  start_pos_r, end_pos_r;
  logic [15:0]        count_r;
  logic               accept;

  logic               f_vld;
  logic [2:0][2*IW+35:0] f_num;
  logic [2:0][2*IW+1:0]  f_den;
  meta_t              f_meta;

  logic               d_vld;
  logic [2:0][QUO_W:0] d_quo;
  meta_t              d_meta;

  logic               out_valid_r;
  logic [DATA_W-1:0]  pos_r, vel_r, acc_r;
  logic [1:0]         seg_r, status_r;

  function automatic logic [DATA_W-1:0] add_sat(input logic [DATA_W-1:0] base,
                                                input logic [QUO_W:0] q,
                                                input logic neg);
    logic signed [SUM_W-1:0] term;
    logic signed [SUM_W-1:0] sum;
    term = $signed({3'b000, q});
    if (neg) begin
      term = -term;
    end
    sum = $signed({{(SUM_W-DATA_W){base[DATA_W-1]}}, base}) + term;
    if (!sum[SUM_W-1] && (|sum[SUM_W-2:DATA_W-1])) begin
      add_sat = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (sum[SUM_W-1] && !(&sum[SUM_W-2:DATA_W-1])) begin
      add_sat = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      add_sat = sum[DATA_W-1:0];
    end
  endfunction

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_pos_r <= '0;
      end_pos_r   <= '0;
      count_r     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_START: start_pos_r <= cfg_data;
        REG_END:   end_pos_r   <= cfg_data;
        REG_COUNT: count_r     <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  lspb_front #(.IW(IW)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc_vld   (accept),
    .idx       (in_sample_index),
    .start_pos (start_pos_r),
    .end_pos   (end_pos_r),
    .count     (count_r),
    .vld       (f_vld),
    .num       (f_num),
    .den       (f_den),
    .meta      (f_meta)
  );

  lspb_div #(.IW(IW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (f_vld),
    .num      (f_num),
    .den      (f_den),
    .in_meta  (f_meta),
    .out_vld  (d_vld),
    .quo      (d_quo),
    .out_meta (d_meta)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    seg_r    <= d_meta.seg;
    status_r <= d_meta.status;
    if (d_meta.status != ST_OK) begin
      pos_r <= d_meta.base;
      vel_r <= '0;
      acc_r <= '0;
    end else begin
      pos_r <= add_sat(d_meta.base, d_quo[0], d_meta.pos_neg);
      vel_r <= add_sat('0, d_quo[1], d_meta.vel_neg);
      acc_r <= add_sat('0, d_quo[2], d_meta.acc_neg);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_position     = pos_r;
  assign out_velocity     = vel_r;
  assign out_acceleration = acc_r;
  assign out_segment      = seg_r;
  assign out_status       = status_r;

`ifndef NO_ASSERTIONS
  a_fault_seg: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_segment == SEG_ACCEL))
    else $error("faulted result carries a non-zero segment");

  a_fault_rates: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_velocity == '0 && out_acceleration == '0))
    else $error("faulted result carries non-zero rates");

  a_cruise_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_OK && out_segment == SEG_CRUISE) |->
      (out_acceleration == '0))
    else $error("cruise segment with non-zero acceleration");

  a_range_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_RANGE) |-> (out_position == '0))
    else $error("out-of-range index with non-zero position");
`endif

endmodule

### tb/sv/tb.sv
// Self-checking testbench for lspb_trajectory_sample_unit: programs endpoint and
// count registers, sends sample indices and checks every result against a predictor.
// Depends on lspb_pkg and lspb_trajectory_sample_unit.
`timescale 1ns / 100ps

module tb import lspb_pkg::*; ();

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 50;
  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEMS_PER_PROFILE = 45;

  typedef struct {
    logic [31:0] position;
    logic [31:0] velocity;
    logic [31:0] acceleration;
    logic [1:0]  segment;
    logic [1:0]  status;
  } sample_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [15:0] in_sample_index = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = REG_START;
  logic [31:0] cfg_data = '0;
  logic out_valid;
  logic [31:0] out_position, out_velocity, out_acceleration;
  logic [1:0] out_segment, out_status;

  logic signed [31:0] prof_start = 0;
  logic signed [31:0] prof_end = 0;
  logic [15:0] prof_count = 0;

  sample_t expected_samples[$];
  int error_count = 0;
  int results_seen = 0;
  int cycle_count = 0;

  lspb_trajectory_sample_unit uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_sample_index(in_sample_index),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .out_valid(out_valid), .out_position(out_position), .out_velocity(out_velocity),
    .out_acceleration(out_acceleration), .out_segment(out_segment),
    .out_status(out_status)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [127:0] scaled_round(logic [127:0] a, logic [127:0] b,
                                                logic [127:0] den);
    logic [127:0] prod, quo, rem;
    prod = a * b;
    quo = prod / den;
    rem = prod % den;
    if (rem >= den - rem) quo = quo + 1;
    return quo;
  endfunction

  function automatic logic signed [131:0] with_sign(logic [127:0] m, logic neg);
    logic signed [131:0] v;
    v = $signed({4'b0, m});
    return neg ? -v : v;
  endfunction

  function automatic logic [31:0] clamp32(logic signed [131:0] x);
    if (x > 132'sd2147483647) return 32'h7fffffff;
    if (x < -132'sd2147483648) return 32'h80000000;
    return x[31:0];
  endfunction

  function automatic sample_t predict_sample(logic [15:0] idx);
    sample_t r;
    logic signed [131:0] s, e, d, pos, vel, acc;
    logic [127:0] mag, tf, tf2, i, b1, b2, rr;
    logic neg;
    s = 132'(prof_start);
    e = 132'(prof_end);
    d = e - s;
    neg = d < 0;
    mag = neg ? 128'(-d) : 128'(d);
    r.position = '0; r.velocity = '0; r.acceleration = '0;
    r.segment = SEG_ACCEL; r.status = ST_OK;
    if (prof_count < 2) begin
      r.position = prof_start;
      r.status = ST_SHORT;
      return r;
    end
    if (idx >= prof_count) begin
      r.status = ST_RANGE;
      return r;
    end
    i = 128'(idx);
    tf = 128'(prof_count) - 128'd1;
    tf2 = tf * tf;
    b1 = tf / 3;
    b2 = (2 * tf) / 3;
    if (i <= b1) begin
      r.segment = SEG_ACCEL;
      pos = s + with_sign(scaled_round(9 * mag, i * i, 4 * tf2), neg);
      vel = with_sign(scaled_round(9 * mag, i, 2 * tf2), neg);
      acc = with_sign(scaled_round(9 * mag, 1, 2 * tf2), neg);
    end else if (i <= b2) begin
      r.segment = SEG_CRUISE;
      pos = s + with_sign(scaled_round(mag, 6 * i - tf, 4 * tf), neg);
      vel = with_sign(scaled_round(3 * mag, 1, 2 * tf), neg);
      acc = 0;
    end else begin
      rr = tf - i;
      r.segment = SEG_DECEL;
      pos = e - with_sign(scaled_round(9 * mag, rr * rr, 4 * tf2), neg);
      vel = with_sign(scaled_round(9 * mag, rr, 2 * tf2), neg);
      acc = -with_sign(scaled_round(9 * mag, 1, 2 * tf2), neg);
    end
    r.position = clamp32(pos);
    r.velocity = clamp32(vel);
    r.acceleration = clamp32(acc);
    return r;
  endfunction

  always @(posedge clk) begin
    sample_t x;
    if (rst_n && out_valid) begin
      results_seen++;
      if (expected_samples.size() == 0) begin
        $error("unexpected result transaction");
        error_count++;
      end else begin
        x = expected_samples.pop_front();
        if (out_position !== x.position) begin
          $error("position: expected %h, got %h", x.position, out_position);
          error_count++;
        end
        if (out_velocity !== x.velocity) begin
          $error("velocity: expected %h, got %h", x.velocity, out_velocity);
          error_count++;
        end
        if (out_acceleration !== x.acceleration) begin
          $error("acceleration: expected %h, got %h", x.acceleration, out_acceleration);
          error_count++;
        end
        if (out_segment !== x.segment) begin
          $error("segment: expected %0d, got %0d", x.segment, out_segment);
          error_count++;
        end
        if (out_status !== x.status) begin
          $error("status: expected %0d, got %0d", x.status, out_status);
          error_count++;
        end
      end
    end
  end

  task automatic send_sample(logic [15:0] idx);
    @(negedge clk);
    start = 1'b1;
    in_sample_index = idx;
    do @(posedge clk); while (busy);
    expected_samples = {expected_samples, predict_sample(idx)};
  endtask

  task automatic go_idle();
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic drain();
    go_idle();
    wait (expected_samples.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_START: prof_start = value;
      REG_END:   prof_end = value;
      REG_COUNT: prof_count = value[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_profile(logic [31:0] s, logic [31:0] e, logic [15:0] n);
    drain();
    write_reg(REG_START, s);
    write_reg(REG_END, e);
    write_reg(REG_COUNT, {16'h0, n});
  endtask

  task automatic test_reset_state();
    send_sample(16'd0);
    send_sample(16'hffff);
  endtask

  task automatic test_short_count();
    set_profile(32'h0001_0000, 32'h0005_0000, 16'd1);
    send_sample(16'd0);
    send_sample(16'd7);
    set_profile(32'h8000_0000, 32'h7fff_ffff, 16'd0);
    send_sample(16'd0);
  endtask

  task automatic test_segments_and_range();
    set_profile(32'h0000_0000, 32'h000a_0000, 16'd10);
    for (int k = 0; k < 10; k++) send_sample(k[15:0]);
    send_sample(16'd10);
    send_sample(16'hffff);
    set_profile(32'h0003_0000, 32'h0003_0000, 16'd4);
    send_sample(16'd0);
    send_sample(16'd3);
  endtask

  task automatic test_extremes();
    set_profile(32'h8000_0000, 32'h7fff_ffff, 16'd2);
    send_sample(16'd0);
    send_sample(16'd1);
    set_profile(32'h7fff_ffff, 32'h8000_0000, 16'hffff);
    send_sample(16'd0);
    send_sample(16'd30000);
    send_sample(16'hfffe);
    drain();
    write_reg(REG_UNUSED, 32'h1234_5678);
    send_sample(16'd1);
  endtask

  task automatic test_random_profiles();
    int sent, burst, gap;
    logic [15:0] n, idx;
    for (int p = 0; p < 40; p++) begin
      case ($urandom_range(0, 9))
        0: n = 16'hffff;
        1: n = 16'($urandom_range(0, 3));
        2: n = 16'($urandom);
        default: n = 16'($urandom_range(2, 300));
      endcase
      if ($urandom_range(0, 7) == 0)
        set_profile($urandom, $urandom, n);
      else
        set_profile($signed($urandom_range(0, 16'hffff)) - 32'sh8000 <<< 8,
                    $urandom, n);
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, $urandom);
      sent = 0;
      while (sent < ITEMS_PER_PROFILE) begin
        burst = $urandom_range(1, 20);
        for (int b = 0; b < burst && sent < ITEMS_PER_PROFILE; b++) begin
          case ($urandom_range(0, 9))
            0: idx = 16'($urandom);
            1: idx = 16'(n + $urandom_range(0, 3));
            default: idx = (n == 0) ? 16'd0 : 16'($urandom_range(0, n - 1));
          endcase
          send_sample(idx);
          sent++;
        end
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          go_idle();
          repeat (gap - 1) @(negedge clk);
        end
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_state();
    test_short_count();
    test_segments_and_range();
    test_extremes();
    test_random_profiles();
    drain();
    $display("Run covered reset defaults, short counts, range errors, all three segments,");
    $display("saturating extremes and %0d checked results over random profiles.",
             results_seen);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### files.f
sv/lspb_pkg.sv
sv/lspb_front.sv
sv/lspb_div.sv
sv/lspb_trajectory_sample_unit.sv
tb/sv/tb.sv
